// ===== src/clrs_pkg.sv =====
// Shared types and constants for the clipped run-slice line span unit.
package clrs_pkg;

    localparam int COORD_BITS_DEF = 16;

    // per-line span generation mode
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SINGLE,
        MODE_DIAG,
        MODE_FIRST,
        MODE_MID,
        MODE_LAST
    } mode_t;

    // setup sequencer
    typedef enum logic [3:0] {
        ST_READY,
        ST_DIFF,
        ST_CLASS,
        ST_DIV_RUN,
        ST_WAIT_RUN,
        ST_MUL_F,
        ST_DIV_F,
        ST_WAIT_F,
        ST_MUL_L,
        ST_DIV_L,
        ST_WAIT_L,
        ST_FIX
    } state_t;

endpackage

// ===== src/clrs_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the line setup.
module clrs_div #(
    parameter int NW = 33,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   shifted;
    logic          ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NW-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(shifted - {1'b0, dvs_reg}) : shifted[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/clipped_run_slice_line_spans_unit.sv =====
// Top level: run-slice line span generator with clip-exact end runs.
//
//  channel | dir | tdata (low bit up)                          | tuser      | tlast
//  s_*     | in  | 8 coords, start_was_clipped, end_was_..., visible | cmd  | -
//  m_*     | out | span_x, span_y, span_length, span_vertical  | span_valid | span_last
//
// Advance beats are registered into the output, one span per cycle unless stalled.
// A start beat is acknowledged at once, then setup holds tready low while it
// classifies the line and runs the bit-serial divider up to three times.
// Reset clears the sequencer, the line mode and the output valid.
// A stalled output blocks further input until the waiting beat is taken.
module clipped_run_slice_line_spans_unit #(
    parameter int COORD_BITS = clrs_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // orig_start_x, orig_start_y, orig_end_x, orig_end_y, clip_start_x, clip_start_y,
    // clip_end_x, clip_end_y, start_was_clipped, end_was_clipped, visible
    input  logic [((8*COORD_BITS+3+7)/8)*8-1:0]   s_tdata,
    input  logic                                  s_tuser,  // cmd
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // span_x, span_y, span_length, span_vertical
    output logic [((3*COORD_BITS+2+7)/8)*8-1:0]   m_tdata,
    output logic                                  m_tuser,  // span_valid
    output logic                                  m_tlast   // span_last
);

    localparam int C     = COORD_BITS;
    localparam int LW    = 2*C + 2;
    localparam int NW    = 2*C + 1;
    localparam int EW    = C + 3;
    localparam int IN_F  = 8*C + 3;
    localparam int OUT_W = ((3*C+2+7)/8)*8;
    localparam logic [LW-1:0] LMAX = LW'(1) << C;

    clrs_pkg::state_t st_reg, st_next;
    clrs_pkg::mode_t  mode_reg, mode_next;

    logic [IN_F-1:0] in_reg, in_next;
    logic            xneg_reg, xneg_next, yneg_reg, yneg_next, vert_reg, vert_next;
    logic [C-1:0]    cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [EW-1:0]   err_reg, err_next;
    logic [C-1:0]    run_reg, run_next;
    logic [C:0]      eup_reg, eup_next, edown_reg, edown_next;
    logic [LW-1:0]   fl_reg, fl_next, ll_reg, ll_next;
    logic [C:0]      spans_reg, spans_next;
    logic [C:0]      dx_reg, dx_next, dy_reg, dy_next;
    logic [C-1:0]    odx_reg, odx_next, ody_reg, ody_next;
    logic [C-1:0]    cfx_reg, cfx_next, cfy_reg, cfy_next;
    logic [C-1:0]    clx_reg, clx_next, cly_reg, cly_next;
    logic [C-1:0]    dmaj_reg, dmaj_next, dmin_reg, dmin_next;
    logic [NW-1:0]   d_reg, d_next;

    logic             ov_reg, ov_next;
    logic [OUT_W-1:0] od_reg, od_next;
    logic             ou_reg, ou_next, ol_reg, ol_next;

    logic            accept, adv;
    logic            div_start, div_done;
    logic [NW-1:0]   div_a, div_q;
    logic [C:0]      div_b, div_r;

    // field views
    logic [C-1:0] ox1, oy1, ox2, oy2, x1, y1, x2, y2;
    logic         cf, cl, vis, mnrneg;

    // setup scratch
    logic [C:0]    dy_raw, ody_raw, dx_raw, odx_raw, ody_abs, odx_abs;
    logic [C:0]    m_fx, m_fy, m_lx, m_ly;
    logic          ymaj_c;
    logic [C-1:0]  dmaj_c, dmin_c;
    logic [C:0]    cmin_c;
    logic [NW-1:0] mul_a, mul_b;
    logic [C-1:0]  cdmaj_f, cdmaj_l;
    logic          rz;

    // span scratch
    logic [EW-1:0] e_sum;
    logic          inc;
    logic [LW-1:0] elen, slen_sat;
    logic [C-1:0]  elen_c, maj, mnr, origin, maj_new, mnr_new, sx, sy;
    logic          majneg;

    function automatic logic [C:0] fl_sat(input logic [LW-1:0] v);
        logic [C:0] res;
        if (v[LW-1])
            res = '0;
        else if (v > LMAX)
            res = LMAX[C:0];
        else
            res = v[C:0];
        return res;
    endfunction

    assign ox1 = in_reg[0*C +: C];
    assign oy1 = in_reg[1*C +: C];
    assign ox2 = in_reg[2*C +: C];
    assign oy2 = in_reg[3*C +: C];
    assign x1  = in_reg[4*C +: C];
    assign y1  = in_reg[5*C +: C];
    assign x2  = in_reg[6*C +: C];
    assign y2  = in_reg[7*C +: C];
    assign cf  = in_reg[8*C];
    assign cl  = in_reg[8*C+1];
    assign vis = in_reg[8*C+2];
    assign mnrneg = vert_reg ? xneg_reg : yneg_reg;

    assign accept = s_tvalid && s_tready;
    assign adv    = accept && s_tuser;

    clrs_div #(.NW(NW), .DW(C+1)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            clrs_pkg::ST_READY:
                if (accept && !s_tuser)
                    st_next = clrs_pkg::ST_DIFF;
            clrs_pkg::ST_DIFF:
                st_next = clrs_pkg::ST_CLASS;
            clrs_pkg::ST_CLASS:
                if (vis && dx_reg != '0 && dy_reg != '0 && odx_reg != ody_reg
                    && dmin_c != '0)
                    st_next = clrs_pkg::ST_DIV_RUN;
                else
                    st_next = clrs_pkg::ST_READY;
            clrs_pkg::ST_DIV_RUN:
                st_next = clrs_pkg::ST_WAIT_RUN;
            clrs_pkg::ST_WAIT_RUN:
                if (div_done)
                    st_next = cf ? clrs_pkg::ST_MUL_F
                            : (cl ? clrs_pkg::ST_MUL_L : clrs_pkg::ST_FIX);
            clrs_pkg::ST_MUL_F:
                st_next = clrs_pkg::ST_DIV_F;
            clrs_pkg::ST_DIV_F:
                st_next = clrs_pkg::ST_WAIT_F;
            clrs_pkg::ST_WAIT_F:
                if (div_done)
                    st_next = cl ? clrs_pkg::ST_MUL_L : clrs_pkg::ST_FIX;
            clrs_pkg::ST_MUL_L:
                st_next = clrs_pkg::ST_DIV_L;
            clrs_pkg::ST_DIV_L:
                st_next = clrs_pkg::ST_WAIT_L;
            clrs_pkg::ST_WAIT_L:
                if (div_done)
                    st_next = clrs_pkg::ST_FIX;
            clrs_pkg::ST_FIX:
                st_next = clrs_pkg::ST_READY;
            default:
                st_next = clrs_pkg::ST_READY;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_a     = d_reg;
        div_b     = {dmin_reg, 1'b0};
        unique case (st_reg)
            clrs_pkg::ST_READY:
                s_tready = !ov_reg || m_tready;
            clrs_pkg::ST_DIV_RUN:
            begin
                div_start = 1'b1;
                div_a     = NW'(dmaj_reg);
                div_b     = {1'b0, dmin_reg};
            end
            clrs_pkg::ST_DIV_F,
            clrs_pkg::ST_DIV_L:
                div_start = 1'b1;
            default:
                s_tready = 1'b0;
        endcase
    end

    // span arithmetic for an advance beat
    always_comb
    begin
        e_sum = err_reg + EW'(eup_reg);
        inc   = mnrneg ? !e_sum[EW-1] : (!e_sum[EW-1] && e_sum != '0);
        case (mode_reg)
            clrs_pkg::MODE_FIRST: elen = fl_reg;
            clrs_pkg::MODE_MID:   elen = LW'(run_reg) + LW'(inc);
            clrs_pkg::MODE_LAST:  elen = ll_reg;
            default:              elen = fl_reg;
        endcase
        elen_c  = elen[C-1:0];
        maj     = vert_reg ? cur_y_reg : cur_x_reg;
        mnr     = vert_reg ? cur_x_reg : cur_y_reg;
        majneg  = vert_reg ? yneg_reg : xneg_reg;
        origin  = majneg ? maj - elen_c + C'(1) : maj;
        maj_new = majneg ? maj - elen_c : maj + elen_c;
        mnr_new = mnrneg ? mnr - C'(1) : mnr + C'(1);
        sx      = vert_reg ? mnr : origin;
        sy      = vert_reg ? origin : mnr;
        if (elen[LW-1])
            slen_sat = '0;
        else if (elen > LMAX)
            slen_sat = LMAX;
        else
            slen_sat = elen;
    end

    // setup arithmetic
    always_comb
    begin
        dy_raw  = {y2[C-1], y2} - {y1[C-1], y1};
        ody_raw = {oy2[C-1], oy2} - {oy1[C-1], oy1};
        dx_raw  = {x2[C-1], x2} - {x1[C-1], x1};
        odx_raw = {ox2[C-1], ox2} - {ox1[C-1], ox1};
        ody_abs = ody_raw[C] ? -ody_raw : ody_raw;
        odx_abs = odx_raw[C] ? -odx_raw : odx_raw;
        m_fx    = {x1[C-1], x1} - {ox1[C-1], ox1};
        m_fy    = {y1[C-1], y1} - {oy1[C-1], oy1};
        m_lx    = {x2[C-1], x2} - {ox2[C-1], ox2};
        m_ly    = {y2[C-1], y2} - {oy2[C-1], oy2};
        if (m_fx[C]) m_fx = -m_fx;
        if (m_fy[C]) m_fy = -m_fy;
        if (m_lx[C]) m_lx = -m_lx;
        if (m_ly[C]) m_ly = -m_ly;
        ymaj_c  = ody_reg > odx_reg;
        dmaj_c  = ymaj_c ? ody_reg : odx_reg;
        dmin_c  = ymaj_c ? odx_reg : ody_reg;
        cmin_c  = ymaj_c ? dx_reg : dy_reg;
        cdmaj_f = vert_reg ? cfy_reg : cfx_reg;
        cdmaj_l = vert_reg ? cly_reg : clx_reg;
        if (st_reg == clrs_pkg::ST_MUL_F)
            mul_a = NW'({(vert_reg ? cfx_reg : cfy_reg), 1'b1});
        else
            mul_a = NW'({(vert_reg ? clx_reg : cly_reg), 1'b1});
        mul_b = NW'(dmaj_reg);
        rz    = div_r == '0;
    end

    // register updates
    always_comb
    begin
        in_next    = in_reg;
        mode_next  = mode_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        vert_next  = vert_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        err_next   = err_reg;
        run_next   = run_reg;
        eup_next   = eup_reg;
        edown_next = edown_reg;
        fl_next    = fl_reg;
        ll_next    = ll_reg;
        spans_next = spans_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        odx_next   = odx_reg;
        ody_next   = ody_reg;
        cfx_next   = cfx_reg;
        cfy_next   = cfy_reg;
        clx_next   = clx_reg;
        cly_next   = cly_reg;
        dmaj_next  = dmaj_reg;
        dmin_next  = dmin_reg;
        d_next     = d_reg;
        ov_next    = ov_reg && !m_tready;
        od_next    = od_reg;
        ou_next    = ou_reg;
        ol_next    = ol_reg;

        if (accept)
        begin
            ov_next = 1'b1;
            od_next = '0;
            ou_next = 1'b0;
            ol_next = 1'b0;
        end

        case (st_reg)
            clrs_pkg::ST_READY:
                if (accept && !s_tuser)
                begin
                    in_next   = s_tdata[IN_F-1:0];
                    mode_next = clrs_pkg::MODE_IDLE;
                end
                else if (adv)
                begin
                    case (mode_reg)
                        clrs_pkg::MODE_SINGLE:
                        begin
                            ou_next   = 1'b1;
                            ol_next   = 1'b1;
                            od_next   = OUT_W'({vert_reg, fl_sat(fl_reg), cur_y_reg,
                                                cur_x_reg});
                            mode_next = clrs_pkg::MODE_IDLE;
                        end
                        clrs_pkg::MODE_DIAG:
                        begin
                            ou_next    = 1'b1;
                            ol_next    = spans_reg == (C+1)'(1);
                            od_next    = OUT_W'({1'b0, (C+1)'(1), cur_y_reg, cur_x_reg});
                            cur_x_next = xneg_reg ? cur_x_reg - C'(1) : cur_x_reg + C'(1);
                            cur_y_next = yneg_reg ? cur_y_reg - C'(1) : cur_y_reg + C'(1);
                            spans_next = spans_reg - (C+1)'(1);
                            if (spans_reg == (C+1)'(1))
                                mode_next = clrs_pkg::MODE_IDLE;
                        end
                        clrs_pkg::MODE_FIRST,
                        clrs_pkg::MODE_MID,
                        clrs_pkg::MODE_LAST:
                        begin
                            ou_next = 1'b1;
                            ol_next = mode_reg == clrs_pkg::MODE_LAST;
                            od_next = OUT_W'({vert_reg, slen_sat[C:0], sy, sx});
                            if (vert_reg)
                            begin
                                cur_y_next = maj_new;
                                cur_x_next = mnr_new;
                            end
                            else
                            begin
                                cur_x_next = maj_new;
                                cur_y_next = mnr_new;
                            end
                            if (mode_reg == clrs_pkg::MODE_FIRST)
                                mode_next = (spans_reg != '0) ? clrs_pkg::MODE_MID
                                                              : clrs_pkg::MODE_LAST;
                            else if (mode_reg == clrs_pkg::MODE_MID)
                            begin
                                err_next   = inc ? e_sum - EW'(edown_reg) : e_sum;
                                spans_next = spans_reg - (C+1)'(1);
                                if (spans_reg == (C+1)'(1))
                                    mode_next = clrs_pkg::MODE_LAST;
                            end
                            else
                                mode_next = clrs_pkg::MODE_IDLE;
                        end
                        default:
                            mode_next = clrs_pkg::MODE_IDLE;
                    endcase
                end
            clrs_pkg::ST_DIFF:
            begin
                yneg_next = ody_raw[C];
                dy_next   = ody_raw[C] ? -dy_raw : dy_raw;
                ody_next  = ody_abs[C-1:0];
                xneg_next = odx_raw[C];
                dx_next   = odx_raw[C] ? -dx_raw : dx_raw;
                odx_next  = odx_abs[C-1:0];
                cfx_next  = m_fx[C-1:0];
                cfy_next  = m_fy[C-1:0];
                clx_next  = m_lx[C-1:0];
                cly_next  = m_ly[C-1:0];
            end
            clrs_pkg::ST_CLASS:
            begin
                vert_next = 1'b0;
                if (!vis)
                    mode_next = clrs_pkg::MODE_IDLE;
                else if (dx_reg == '0)
                begin
                    cur_x_next = yneg_reg ? x2 : x1;
                    cur_y_next = yneg_reg ? y2 : y1;
                    fl_next    = {{(LW-C-1){dy_reg[C]}}, dy_reg} + LW'(1);
                    vert_next  = 1'b1;
                    mode_next  = clrs_pkg::MODE_SINGLE;
                end
                else if (dy_reg == '0)
                begin
                    cur_x_next = xneg_reg ? x2 : x1;
                    cur_y_next = xneg_reg ? y2 : y1;
                    fl_next    = {{(LW-C-1){dx_reg[C]}}, dx_reg} + LW'(1);
                    mode_next  = clrs_pkg::MODE_SINGLE;
                end
                else if (odx_reg == ody_reg)
                begin
                    cur_x_next = x1;
                    cur_y_next = y1;
                    spans_next = dx_reg[C] ? '0 : dx_reg + (C+1)'(1);
                    mode_next  = dx_reg[C] ? clrs_pkg::MODE_IDLE : clrs_pkg::MODE_DIAG;
                end
                else
                begin
                    mode_next  = clrs_pkg::MODE_IDLE;
                    vert_next  = ymaj_c;
                    dmaj_next  = dmaj_c;
                    dmin_next  = dmin_c;
                    cur_x_next = x1;
                    cur_y_next = y1;
                    if (!cmin_c[C] && cmin_c != '0 && cmin_c != (C+1)'(1))
                        spans_next = cmin_c - (C+1)'(1);
                    else
                        spans_next = '0;
                end
            end
            clrs_pkg::ST_WAIT_RUN:
                if (div_done)
                begin
                    run_next   = div_q[C-1:0];
                    fl_next    = LW'(div_q[C-1:1]) + LW'(1);
                    ll_next    = LW'(div_q[C-1:1]) + LW'(1);
                    eup_next   = {div_r[C-1:0], 1'b0};
                    edown_next = {dmin_reg, 1'b0};
                    err_next   = EW'(div_r[C-1:0]) - EW'({dmin_reg, 1'b0})
                               + (div_q[0] ? EW'(dmin_reg) : EW'(0));
                end
            clrs_pkg::ST_MUL_F,
            clrs_pkg::ST_MUL_L:
                d_next = mul_a * mul_b;
            clrs_pkg::ST_WAIT_F:
                if (div_done)
                begin
                    fl_next  = LW'(div_q) - LW'(cdmaj_f) + LW'(1)
                             - LW'(rz && !mnrneg);
                    err_next = (rz && !mnrneg) ? EW'(0)
                             : EW'(div_r) - EW'({dmin_reg, 1'b0});
                end
            clrs_pkg::ST_WAIT_L:
                if (div_done)
                    ll_next = LW'(div_q) - LW'(cdmaj_l) + LW'(1) - LW'(rz && mnrneg);
            clrs_pkg::ST_FIX:
            begin
                mode_next = clrs_pkg::MODE_FIRST;
                if (eup_reg == '0 && !run_reg[0])
                begin
                    if (!mnrneg && !cf)
                        fl_next = fl_reg - LW'(1);
                    if (mnrneg && !cl)
                        ll_next = ll_reg - LW'(1);
                end
            end
            default:
                mode_next = mode_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= clrs_pkg::ST_READY;
            mode_reg  <= clrs_pkg::MODE_IDLE;
            ov_reg    <= 1'b0;
            xneg_reg  <= 1'b0;
            yneg_reg  <= 1'b0;
            vert_reg  <= 1'b0;
            spans_reg <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            mode_reg  <= mode_next;
            ov_reg    <= ov_next;
            xneg_reg  <= xneg_next;
            yneg_reg  <= yneg_next;
            vert_reg  <= vert_next;
            spans_reg <= spans_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg    <= in_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        err_reg   <= err_next;
        run_reg   <= run_next;
        eup_reg   <= eup_next;
        edown_reg <= edown_next;
        fl_reg    <= fl_next;
        ll_reg    <= ll_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        odx_reg   <= odx_next;
        ody_reg   <= ody_next;
        cfx_reg   <= cfx_next;
        cfy_reg   <= cfy_next;
        clx_reg   <= clx_next;
        cly_reg   <= cly_next;
        dmaj_reg  <= dmaj_next;
        dmin_reg  <= dmin_next;
        d_reg     <= d_next;
        od_reg    <= od_next;
        ou_reg    <= ou_next;
        ol_reg    <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;
    assign m_tlast  = ol_reg;

    // divider results only land while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (st_reg == clrs_pkg::ST_WAIT_RUN || st_reg == clrs_pkg::ST_WAIT_F
                      || st_reg == clrs_pkg::ST_WAIT_L))
        else $error("divider finished outside a wait state");

    // every accepted beat yields a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted beat produced no result");

    // a last span ends the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (mode_reg == clrs_pkg::MODE_SINGLE || mode_reg == clrs_pkg::MODE_LAST))
        |=> (mode_reg == clrs_pkg::MODE_IDLE && m_tlast))
        else $error("line still running after its last span");

    // a start beat sends the sequencer into setup, which then holds off further input
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser) |=> (st_reg == clrs_pkg::ST_DIFF && !s_tready))
        else $error("setup did not begin after a start beat");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the clipped run-slice line span unit.
`timescale 1ns / 1ps

module tb;

    localparam bit CMD_START   = 1'b0;
    localparam bit CMD_ADVANCE = 1'b1;
    // direction flag bits
    localparam int XN = 0;
    localparam int YN = 1;
    localparam int VT = 2;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] osx, osy, oex, oey, csx, csy, cex, cey;
        logic               cf, cl, vis;
    } beat_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] x, y;
        logic [16:0] len;
        logic        vert, last;
    } span_t;

    typedef struct {
        beat_t b;
        bit    typed;
        span_t t;
    } row_t;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [55:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    clipped_run_slice_line_spans_unit #(.COORD_BITS(16)) DUT (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // line state of the span predictor
    longint cx, cy, err, run, eup, edn, flen, llen, left;
    clrs_pkg::mode_t mode = clrs_pkg::MODE_IDLE;
    bit [2:0] dirf = '0;

    span_t expq[$];
    int    errors = 0;
    int    sent = 0;
    bit    calm = 0;
    bit    press_req = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic span_t mk_span(longint x, longint y, longint len, bit vert, bit last);
        span_t s;
        if (len < 0) len = 0;
        if (len > 65536) len = 65536;
        s.valid = 1;
        s.x = 16'(x);
        s.y = 16'(y);
        s.len = 17'(len);
        s.vert = vert;
        s.last = last;
        return s;
    endfunction

    function automatic span_t emit_run(longint len, bit last);
        bit ym, majneg, mnneg;
        longint maj, mnr, org, mpos;
        ym = dirf[VT];
        majneg = dirf[ym ? YN : XN];
        mnneg = dirf[ym ? XN : YN];
        maj = ym ? cy : cx;
        mnr = ym ? cx : cy;
        org = majneg ? maj - len + 1 : maj;
        mpos = mnr;
        maj = majneg ? maj - len : maj + len;
        mnr += mnneg ? -1 : 1;
        if (ym)
        begin
            cy = maj;
            cx = mnr;
        end
        else
        begin
            cx = maj;
            cy = mnr;
        end
        return mk_span(ym ? mpos : org, ym ? org : mpos, len, ym, last);
    endfunction

    function automatic void line_setup(beat_t b);
        longint ox1, oy1, ox2, oy2, x1, y1, x2, y2, dx, dy, odx, ody;
        longint dmaj, dmin, cmin, cdmaj, cdmin, d, q, r;
        bit ymaj, mn;
        ox1 = b.osx; oy1 = b.osy; ox2 = b.oex; oy2 = b.oey;
        x1 = b.csx; y1 = b.csy; x2 = b.cex; y2 = b.cey;
        mode = clrs_pkg::MODE_IDLE;
        left = 0;
        dirf = '0;
        if (!b.vis)
            return;
        dy = y2 - y1; ody = oy2 - oy1;
        if (ody < 0)
        begin
            ody = -ody; dy = -dy; dirf[YN] = 1;
        end
        dx = x2 - x1; odx = ox2 - ox1;
        if (odx < 0)
        begin
            odx = -odx; dx = -dx; dirf[XN] = 1;
        end
        if (dx == 0)
        begin
            cx = dirf[YN] ? x2 : x1;
            cy = dirf[YN] ? y2 : y1;
            flen = dy + 1;
            dirf[VT] = 1;
            mode = clrs_pkg::MODE_SINGLE;
            return;
        end
        if (dy == 0)
        begin
            cx = dirf[XN] ? x2 : x1;
            cy = dirf[XN] ? y2 : y1;
            flen = dx + 1;
            mode = clrs_pkg::MODE_SINGLE;
            return;
        end
        if (odx == ody)
        begin
            cx = x1; cy = y1;
            left = dx >= 0 ? dx + 1 : 0;
            mode = left != 0 ? clrs_pkg::MODE_DIAG : clrs_pkg::MODE_IDLE;
            return;
        end
        ymaj = ody > odx;
        dmaj = ymaj ? ody : odx;
        dmin = ymaj ? odx : ody;
        if (dmin == 0)
            return;
        cmin = ymaj ? dx : dy;
        mn = dirf[ymaj ? XN : YN];
        if (ymaj) dirf[VT] = 1;
        run = dmaj / dmin;
        r = dmaj % dmin;
        flen = (run >>> 1) + 1;
        llen = flen;
        if (b.cf)
        begin
            cdmaj = mag(ymaj ? y1 - oy1 : x1 - ox1);
            cdmin = mag(ymaj ? x1 - ox1 : y1 - oy1);
            d = (2 * cdmin + 1) * dmaj;
            q = d / (2 * dmin);
            err = d % (2 * dmin);
            flen = q - cdmaj + 1;
            if (err == 0 && !mn)
            begin
                flen--;
                err += 2 * dmin;
            end
            err -= 2 * dmin;
        end
        else
        begin
            err = r - 2 * dmin;
            if (run[0]) err += dmin;
        end
        if (b.cl)
        begin
            cdmaj = mag(ymaj ? y2 - oy2 : x2 - ox2);
            cdmin = mag(ymaj ? x2 - ox2 : y2 - oy2);
            d = (2 * cdmin + 1) * dmaj;
            llen = d / (2 * dmin) - cdmaj + 1;
            if (mn && d % (2 * dmin) == 0) llen--;
        end
        eup = 2 * r;
        edn = 2 * dmin;
        if (eup == 0 && !run[0])
        begin
            if (!mn && !b.cf) flen--;
            if (mn && !b.cl) llen--;
        end
        cx = x1; cy = y1;
        left = cmin > 1 ? cmin - 1 : 0;
        mode = clrs_pkg::MODE_FIRST;
    endfunction

    function automatic span_t predict_span(beat_t b);
        span_t s;
        longint len;
        bit mn;
        s = '0;
        if (b.cmd == CMD_START)
        begin
            line_setup(b);
            return s;
        end
        case (mode)
            clrs_pkg::MODE_SINGLE:
            begin
                s = mk_span(cx, cy, flen, dirf[VT], 1'b1);
                mode = clrs_pkg::MODE_IDLE;
            end
            clrs_pkg::MODE_DIAG:
            begin
                s = mk_span(cx, cy, 1, 1'b0, left == 1);
                cx += dirf[XN] ? -1 : 1;
                cy += dirf[YN] ? -1 : 1;
                left--;
                if (left == 0) mode = clrs_pkg::MODE_IDLE;
            end
            clrs_pkg::MODE_FIRST:
            begin
                s = emit_run(flen, 1'b0);
                mode = left != 0 ? clrs_pkg::MODE_MID : clrs_pkg::MODE_LAST;
            end
            clrs_pkg::MODE_MID:
            begin
                mn = dirf[dirf[VT] ? XN : YN];
                len = run;
                err += eup;
                if (mn ? err >= 0 : err > 0)
                begin
                    len++;
                    err -= edn;
                end
                s = emit_run(len, 1'b0);
                left--;
                if (left == 0) mode = clrs_pkg::MODE_LAST;
            end
            clrs_pkg::MODE_LAST:
            begin
                s = emit_run(llen, 1'b1);
                mode = clrs_pkg::MODE_IDLE;
            end
            default: mode = clrs_pkg::MODE_IDLE;
        endcase
        return s;
    endfunction

    function automatic beat_t rand_beat(bit cmd);
        beat_t b;
        b = beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        b.cmd = cmd;
        return b;
    endfunction

    function automatic beat_t line_beat(int ox1, int oy1, int ox2, int oy2, int x1, int y1,
                                        int x2, int y2, bit cf, bit cl, bit vis);
        beat_t b;
        b.cmd = CMD_START;
        b.osx = 16'(ox1); b.osy = 16'(oy1); b.oex = 16'(ox2); b.oey = 16'(oy2);
        b.csx = 16'(x1); b.csy = 16'(y1); b.cex = 16'(x2); b.cey = 16'(y2);
        b.cf = cf; b.cl = cl; b.vis = vis;
        return b;
    endfunction

    function automatic beat_t make_line();
        int kind, x1, y1, dx, dy, k1, k2;
        kind = $urandom_range(0, 11);
        if (kind == 0)
            return rand_beat(CMD_START);
        x1 = $urandom_range(0, 3) == 0 ? int'($signed(16'($urandom)))
                                        : int'($urandom_range(0, 400)) - 200;
        y1 = $urandom_range(0, 3) == 0 ? int'($signed(16'($urandom)))
                                        : int'($urandom_range(0, 400)) - 200;
        dx = int'($urandom_range(0, 120)) - 60;
        dy = int'($urandom_range(0, 120)) - 60;
        case (kind)
            1: dx = 0;
            2: dy = 0;
            3: dy = $urandom_range(0, 1) ? dx : -dx;
            4:
            begin
                dx = int'($urandom_range(0, 60000)) - 30000;
                dy = int'($urandom_range(0, 6)) - 3;
            end
            5:
            begin
                dy = int'($urandom_range(0, 60000)) - 30000;
                dx = int'($urandom_range(0, 6)) - 3;
            end
            default: ;
        endcase
        k1 = $urandom_range(0, 2) == 0 ? $urandom_range(1, 7) : 0;
        k2 = $urandom_range(0, 2) == 0 ? $urandom_range(1, 7) : 0;
        make_line = line_beat(x1, y1, x1 + dx, y1 + dy,
                              x1 + dx * k1 / 16, y1 + dy * k1 / 16,
                              x1 + dx - dx * k2 / 16, y1 + dy - dy * k2 / 16,
                              k1 != 0, k2 != 0, $urandom_range(0, 15) != 0);
        if ($urandom_range(0, 15) == 0)
        begin
            // random flags that may disagree with the clipped points
            make_line.cf = $urandom;
            make_line.cl = $urandom;
        end
    endfunction

    task automatic send(beat_t b, bit typed, span_t t);
        span_t p;
        p = predict_span(b);
        expq.push_back(typed ? t : p);
        s_tvalid <= 1;
        s_tuser <= b.cmd;
        s_tdata <= {5'b0, b.vis, b.cl, b.cf, b.cey, b.cex, b.csy, b.csx,
                    b.oey, b.oex, b.osy, b.osx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
        if (sent == 400) press_req = 1;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // output side: checks each beat, with random stalls plus one long hold-off
    initial
    begin
        int stall_cnt;
        int hold_cnt;
        span_t got, want;
        stall_cnt = 0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[48:32],
                       m_tdata[49], m_tlast};
                if (expq.size() == 0)
                begin
                    $error("unexpected beat on output");
                    errors++;
                end
                else
                begin
                    want = expq.pop_front();
                    if (got.valid !== want.valid)
                    begin
                        $error("span_valid exp %0h got %0h", want.valid, got.valid); errors++;
                    end
                    if (got.x !== want.x)
                    begin
                        $error("span_x exp %0h got %0h", want.x, got.x); errors++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("span_y exp %0h got %0h", want.y, got.y); errors++;
                    end
                    if (got.len !== want.len)
                    begin
                        $error("span_length exp %0d got %0d", want.len, got.len); errors++;
                    end
                    if (got.vert !== want.vert)
                    begin
                        $error("span_vertical exp %0h got %0h", want.vert, got.vert); errors++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("span_last exp %0h got %0h", want.last, got.last); errors++;
                    end
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 0;
            end
            else if (press_req)
            begin
                press_req = 0;
                hold_cnt = 300;
                m_tready <= 0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                m_tready <= 0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_cnt = $urandom_range(0, 18);
                m_tready <= 0;
            end
            else
                m_tready <= 1;
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        span_t z;
        int adv_cap, n;
        z = '0;
        rw.typed = 1;
        rw.t = z;
        // idle advance straight after reset
        rw.b = rand_beat(CMD_ADVANCE); rows.push_back(rw);
        // rejected line
        rw.b = line_beat(0, 0, 5, 9, 0, 0, 5, 9, 0, 0, 0); rows.push_back(rw);
        rw.b = rand_beat(CMD_ADVANCE); rows.push_back(rw);
        // full-width horizontal and full-height vertical
        rw.b = line_beat(-32768, 0, 32767, 0, -32768, 0, 32767, 0, 0, 0, 1); rows.push_back(rw);
        rw.b = rand_beat(CMD_ADVANCE); rw.t = '{1, 16'h8000, 16'h0, 17'h10000, 0, 1};
        rows.push_back(rw);
        rw.t = z;
        rw.b = line_beat(5, -32768, 5, 32767, 5, -32768, 5, 32767, 0, 0, 1); rows.push_back(rw);
        rw.b = rand_beat(CMD_ADVANCE); rw.t = '{1, 16'h5, 16'h8000, 17'h10000, 1, 1};
        rows.push_back(rw);
        rw.t = z;
        // degenerate minor axis: dropped
        rw.b = line_beat(0, 0, 10, 0, 0, 0, 10, 3, 0, 0, 1); rows.push_back(rw);
        rw.b = rand_beat(CMD_ADVANCE); rows.push_back(rw);
        // diagonal clipped against its direction: no spans
        rw.b = line_beat(0, 0, 3, 3, 3, 3, 0, 0, 0, 0, 1); rows.push_back(rw);
        rw.b = rand_beat(CMD_ADVANCE); rows.push_back(rw);
        rw.typed = 0;
        // falling diagonal
        rw.b = line_beat(10, 10, 7, 7, 10, 10, 7, 7, 0, 0, 1); rows.push_back(rw);
        repeat (4) begin rw.b = rand_beat(CMD_ADVANCE); rows.push_back(rw); end
        // shallow line, abandoned part way by a fresh start
        rw.b = line_beat(0, 0, 20, 7, 0, 0, 20, 7, 0, 0, 1); rows.push_back(rw);
        repeat (3) begin rw.b = rand_beat(CMD_ADVANCE); rows.push_back(rw); end
        // steep line clipped at both ends
        rw.b = line_beat(0, 0, -9, 40, -1, 5, -8, 35, 1, 1, 1); rows.push_back(rw);
        repeat (6) begin rw.b = rand_beat(CMD_ADVANCE); rows.push_back(rw); end

        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (rows[i])
            send(rows[i].b, rows[i].typed, rows[i].t);

        n = 0;
        while (sent < 1850)
        begin
            if (sent > 1650) calm = 1;
            send(make_line(), 0, z);
            adv_cap = $urandom_range(1, 40);
            n = 0;
            while (mode != clrs_pkg::MODE_IDLE && n < adv_cap)
            begin
                send(rand_beat(CMD_ADVANCE), 0, z);
                n++;
            end
            if ($urandom_range(0, 7) == 0)
                send(rand_beat(CMD_ADVANCE), 0, z);
        end
        s_tvalid <= 0;

        while (expq.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
